// ----- rtl/fbsc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fbsc_pkg
// shared types and widths of the frustum box and sphere cull unit
// ============================================================================
package fbsc_pkg;

    localparam int CFG_IDX_W   = 3;   // register index, six plane registers
    localparam int PLANE_W     = 64;  // packed plane a, b, c, d
    localparam int COORD_W     = 16;  // signed Q8.8 center coordinate
    localparam int EXT_W       = 15;  // unsigned Q7.8 half extent or radius
    localparam int COEF_W      = 16;  // signed plane coefficient
    localparam int PROD_W      = 32;  // signed coefficient times coordinate
    localparam int MAG_PROD_W  = 31;  // coefficient magnitude times extent
    localparam int ACC_W       = 35;  // distance sum with headroom, Q.22
    localparam int FRAC_SHIFT  = 14;  // aligns Q8.8 to Q.22
    localparam int S_TDATA_W   = 112; // seven payload fields padded to bytes
    localparam int M_TDATA_W   = 8;   // visible flag padded to a byte

    // test selector carried in tuser
    typedef enum logic {
        ACT_BOX    = 1'b0,
        ACT_SPHERE = 1'b1
    } action_t;

    // one query as it travels down the chain of plane cells
    typedef struct packed {
        action_t                    action;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  center_z;
        logic [EXT_W-1:0]           half_x;
        logic [EXT_W-1:0]           half_y;
        logic [EXT_W-1:0]           half_z;
        logic [EXT_W-1:0]           sphere_radius;
        logic                       visible;
    } item_t;

endpackage

// ----- rtl/frustum_box_sphere_cull_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// frustum_box_sphere_cull_unit
// view frustum culling of axis-aligned boxes and spheres against six planes
// ============================================================================
// usage
//   planes are written over the cfg port (index 0..5: right, left, bottom,
//   top, far, near), each packed as a, b, c in Q1.14 and d in Q8.8; write
//   only while no query is in flight
//   a query beat on s_axis carries center, half sizes and radius in tdata
//   and the box or sphere selector in tuser; one result beat per query
//   on m_axis gives visible in tdata bit 0
// throughput and pipeline
//   one query per cycle while m_axis_tready holds high; the path from the
//   input beat to the result beat is the chain of plane cells (products in
//   one stage, distance sum and compare in the next) plus the output buffer
// reset
//   all plane registers clear to zero: boxes then come back culled and
//   spheres visible; all pipeline stages empty
// stalls
//   when m_axis_tready is low results collect in the two-entry output buffer
//   and the cells behind it fill up before s_axis_tready drops
// ============================================================================
module frustum_box_sphere_cull_unit
#(
    parameter int NUM_PLANES = 6
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [fbsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbsc_pkg::PLANE_W-1:0]       cfg_wdata,
    // query stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, sphere_radius
    input  logic [fbsc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // visible
    output logic [fbsc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import fbsc_pkg::*;

    // hop p feeds cell p; the last hop goes to the output buffer
    logic  hop_valid [NUM_PLANES+1];
    logic  hop_ready [NUM_PLANES+1];
    item_t hop_item  [NUM_PLANES+1];
    logic  out_visible;

    // unpack the query beat; every query starts out visible
    always_comb
    begin
        hop_item[0].action        = action_t'(s_axis_tuser);
        hop_item[0].center_x      = s_axis_tdata[15:0];
        hop_item[0].center_y      = s_axis_tdata[31:16];
        hop_item[0].center_z      = s_axis_tdata[47:32];
        hop_item[0].half_x        = s_axis_tdata[62:48];
        hop_item[0].half_y        = s_axis_tdata[77:63];
        hop_item[0].half_z        = s_axis_tdata[92:78];
        hop_item[0].sphere_radius = s_axis_tdata[107:93];
        hop_item[0].visible       = 1'b1;
    end

    assign hop_valid[0]  = s_axis_tvalid;
    assign s_axis_tready = hop_ready[0];

    // one cell per plane; a write beyond the plane count finds no cell
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fbsc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_we    (cfg_wr_en && (cfg_index == CFG_IDX_W'(p))),
            .cfg_wdata (cfg_wdata),
            .up_valid  (hop_valid[p]),
            .up_ready  (hop_ready[p]),
            .up_item   (hop_item[p]),
            .dn_valid  (hop_valid[p+1]),
            .dn_ready  (hop_ready[p+1]),
            .dn_item   (hop_item[p+1])
        );
    end

    fbsc_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hop_valid[NUM_PLANES]),
        .in_ready   (hop_ready[NUM_PLANES]),
        .in_visible (hop_item[NUM_PLANES].visible),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_visible  (out_visible)
    );

    assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, out_visible};

endmodule

// ----- rtl/fbsc_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fbsc_cell
// one plane of the frustum: holds its plane register and tests each query
// ============================================================================
module fbsc_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fbsc_pkg::PLANE_W-1:0]   cfg_wdata,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  fbsc_pkg::item_t                up_item,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output fbsc_pkg::item_t                dn_item
);
    import fbsc_pkg::*;

    logic [PLANE_W-1:0] plane_reg;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic [COEF_W-1:0] mag_a;
    logic [COEF_W-1:0] mag_b;
    logic [COEF_W-1:0] mag_c;

    // stage a: products
    logic valid_a_reg;
    item_t item_a_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next;
    logic [MAG_PROD_W-1:0] qa_reg, qb_reg, qc_reg;
    logic [MAG_PROD_W-1:0] qa_next, qb_next, qc_next;
    logic signed [COEF_W-1:0] d_reg;

    // stage b: sum and decision
    logic valid_b_reg;
    item_t item_b_reg;
    item_t item_b_next;
    logic ready_a;
    logic ready_b;
    logic signed [ACC_W-1:0] center_dist;
    logic signed [ACC_W-1:0] reach;
    logic signed [ACC_W-1:0] total;
    logic pass;

    assign coef_a = plane_reg[15:0];
    assign coef_b = plane_reg[31:16];
    assign coef_c = plane_reg[47:32];
    assign coef_d = plane_reg[63:48];

    assign mag_a = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : coef_a;
    assign mag_b = coef_b[COEF_W-1] ? COEF_W'(-coef_b) : coef_b;
    assign mag_c = coef_c[COEF_W-1] ? COEF_W'(-coef_c) : coef_c;

    // farthest box corner along the normal adds |n_i| * half_i per axis
    assign pa_next = coef_a * up_item.center_x;
    assign pb_next = coef_b * up_item.center_y;
    assign pc_next = coef_c * up_item.center_z;
    assign qa_next = MAG_PROD_W'(mag_a) * MAG_PROD_W'(up_item.half_x);
    assign qb_next = MAG_PROD_W'(mag_b) * MAG_PROD_W'(up_item.half_y);
    assign qc_next = MAG_PROD_W'(mag_c) * MAG_PROD_W'(up_item.half_z);

    assign ready_b  = !valid_b_reg || dn_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign up_ready = ready_a;

    always_comb
    begin
        center_dist = ACC_W'(pa_reg) + ACC_W'(pb_reg) + ACC_W'(pc_reg)
                    + $signed({{(ACC_W-COEF_W-FRAC_SHIFT){d_reg[COEF_W-1]}},
                               d_reg, {FRAC_SHIFT{1'b0}}});
        if (item_a_reg.action == ACT_SPHERE)
        begin
            reach = $signed({{(ACC_W-EXT_W-FRAC_SHIFT){1'b0}},
                             item_a_reg.sphere_radius, {FRAC_SHIFT{1'b0}}});
        end
        else
        begin
            reach = $signed({{(ACC_W-MAG_PROD_W){1'b0}}, qa_reg})
                  + $signed({{(ACC_W-MAG_PROD_W){1'b0}}, qb_reg})
                  + $signed({{(ACC_W-MAG_PROD_W){1'b0}}, qc_reg});
        end
        total = center_dist + reach;
        // sphere kept when distance >= -radius, box kept when a corner is > 0
        if (item_a_reg.action == ACT_SPHERE)
        begin
            pass = !total[ACC_W-1];
        end
        else
        begin
            pass = !total[ACC_W-1] && (total != '0);
        end
        item_b_next         = item_a_reg;
        item_b_next.visible = item_a_reg.visible && pass;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                plane_reg <= cfg_wdata;
            end
            if (ready_a)
            begin
                valid_a_reg <= up_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && up_valid)
        begin
            item_a_reg <= up_item;
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            pc_reg     <= pc_next;
            qa_reg     <= qa_next;
            qb_reg     <= qb_next;
            qc_reg     <= qc_next;
            d_reg      <= coef_d;
        end
        if (ready_b && valid_a_reg)
        begin
            item_b_reg <= item_b_next;
        end
    end

    assign dn_valid = valid_b_reg;
    assign dn_item  = item_b_reg;

`ifndef ASSERT_OFF
    // a query already culled upstream never becomes visible here
    a_vis_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a_reg && ready_b && !item_a_reg.visible |=> !item_b_reg.visible)
        else $error("fbsc_cell: culled query turned visible");

    // a stalled product stage keeps its query
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a_reg && !ready_b |=> valid_a_reg && $stable(item_a_reg))
        else $error("fbsc_cell: stage a lost a stalled query");

    // backpressure upstream only when both stages are occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !up_ready |-> valid_a_reg && valid_b_reg)
        else $error("fbsc_cell: ready low with a free stage");
`endif

endmodule

// ----- rtl/fbsc_out.sv -----
`timescale 1ns / 1ps
// ============================================================================
// fbsc_out
// two-entry output buffer that holds results and registers the ready path
// ============================================================================
module fbsc_out
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    in_visible,
    output logic    m_valid,
    input  logic    m_ready,
    output logic    m_visible
);

    logic main_valid_reg;
    logic main_vis_reg;
    logic skid_valid_reg;
    logic skid_vis_reg;
    logic take;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            if (main_valid_reg && !m_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_ready)
            begin
                main_vis_reg <= skid_vis_reg;
            end
        end
        else if (take)
        begin
            if (main_valid_reg && !m_ready)
            begin
                skid_vis_reg <= in_visible;
            end
            else
            begin
                main_vis_reg <= in_visible;
            end
        end
    end

    assign m_valid   = main_valid_reg;
    assign m_visible = main_vis_reg;

`ifndef ASSERT_OFF
    // the spare entry is only used behind a full main entry
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("fbsc_out: spare entry filled with main empty");

    // a waiting spare result survives a stall
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_vis_reg))
        else $error("fbsc_out: spare result lost under stall");

    // spare result moves forward when the main one is taken
    a_skid_move: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_ready |=> main_valid_reg && !skid_valid_reg)
        else $error("fbsc_out: spare result not promoted");
`endif

endmodule
